// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside of reset.
`define FFCA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define FFCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ffca_pkg.sv =====
package ffca_pkg;

    localparam int FREE_SLOTS   = 64;
    localparam int USED_SLOTS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_BITS    = 32;

    localparam int FIDX_W  = $clog2(FREE_SLOTS);
    localparam int FCNT_W  = $clog2(FREE_SLOTS + 1);
    localparam int UIDX_W  = $clog2(USED_SLOTS);
    localparam int UCNT_W  = $clog2(USED_SLOTS + 1);
    localparam int COUNT_W = 26;
    localparam int BB_W    = 13;
    localparam int SIZE_W  = COUNT_W + BB_W;
    localparam int ENTRY_W = 2 * ADDR_BITS;

    localparam logic [ADDR_BITS-1:0] HDR_C         = ADDR_BITS'(HEADER_BYTES);
    localparam logic [ADDR_BITS-1:0] REGION_OFFSET = ADDR_BITS'(1 << 24);

    localparam logic [ADDR_BITS-1:0] HEAP_START_RST  = 32'd0;
    localparam logic [ADDR_BITS-1:0] HEAP_END_RST    = 32'd268435456;
    localparam logic [BB_W-1:0]      BLOCK_BYTES_RST = 13'd64;

    localparam logic [1:0] CFG_HEAP_START  = 2'd0;
    localparam logic [1:0] CFG_HEAP_END    = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BYTES = 2'd2;

    typedef enum logic [1:0] {
        KIND_INIT, KIND_ALLOC, KIND_FREE, KIND_QUERY
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK, STS_NO_FIT, STS_FULL, STS_UNKNOWN
    } sts_t;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_A_SLOT, S_A_TEST, S_A_CHK, S_DROP_TEST, S_DROP_WR,
        S_F_START, S_F_UTEST, S_F_UCHK, S_F_PTEST, S_F_PCHK, S_F_DECIDE,
        S_F_MB, S_INS_TEST, S_INS_WR, S_Q_TEST, S_Q_ACC, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_SLOT_INC, OP_FRD, OP_IDX_INC, OP_SET_STS,
        OP_GRANT_WHOLE, OP_GRANT_SPLIT, OP_DROP_RD, OP_DROP_WR, OP_DEC_N,
        OP_URD, OP_UTAKE, OP_PREV, OP_MERGE_AFTER, OP_MERGE_BEFORE,
        OP_INS_START, OP_INS_RD, OP_INS_WR, OP_INS_PUT, OP_QACC, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        sts_t   sts;
    } dp_cmd_t;

    typedef struct packed {
        logic              idx_lt_n;
        logic              drop_more;
        logic              slot_busy;
        logic              slot_end;
        logic              addr_zero;
        logic              fit;
        logic              whole;
        logic              umatch;
        logic              below;
        logic              after;
        logic              prev_adj;
        logic              n_full;
        logic              ins_more;
        logic              out_free;
        logic [FCNT_W-1:0] n_entries;
    } dp_sts_t;

endpackage

// ===== rtl/core/ffca_ram.sv =====
module ffca_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/ffca_ctrl.sv =====
module ffca_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_kind,
    output logic              s_ready,
    input  ffca_pkg::dp_sts_t sts,
    output ffca_pkg::dp_cmd_t cmd,
    output ffca_pkg::state_t  state
);
    import ffca_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, sts: STS_OK};
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    case (kind_t'(s_kind))
                        KIND_INIT:  state_next = S_INIT;
                        KIND_ALLOC: state_next = S_A_SLOT;
                        KIND_FREE:  state_next = S_F_START;
                        default:    state_next = S_Q_TEST;
                    endcase
                end
            end
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_DONE;
            end
            // find a free used-table slot first
            S_A_SLOT: begin
                if (sts.slot_busy) begin
                    cmd.op = OP_SLOT_INC;
                end else begin
                    state_next = S_A_TEST;
                end
            end
            S_A_TEST: begin
                if (sts.idx_lt_n) begin
                    cmd.op     = OP_FRD;
                    state_next = S_A_CHK;
                end else begin
                    cmd        = '{op: OP_SET_STS, sts: STS_NO_FIT};
                    state_next = S_DONE;
                end
            end
            S_A_CHK: begin
                if (!sts.fit) begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_A_TEST;
                end else if (sts.slot_end) begin
                    cmd        = '{op: OP_SET_STS, sts: STS_FULL};
                    state_next = S_DONE;
                end else if (sts.whole) begin
                    cmd.op     = OP_GRANT_WHOLE;
                    state_next = S_DROP_TEST;
                end else begin
                    cmd.op     = OP_GRANT_SPLIT;
                    state_next = S_DONE;
                end
            end
            S_DROP_TEST: begin
                if (sts.drop_more) begin
                    cmd.op     = OP_DROP_RD;
                    state_next = S_DROP_WR;
                end else begin
                    cmd.op     = OP_DEC_N;
                    state_next = S_DONE;
                end
            end
            S_DROP_WR: begin
                cmd.op     = OP_DROP_WR;
                state_next = S_DROP_TEST;
            end
            S_F_START: begin
                state_next = sts.addr_zero ? S_DONE : S_F_UTEST;
            end
            S_F_UTEST: begin
                if (sts.slot_end) begin
                    cmd        = '{op: OP_SET_STS, sts: STS_UNKNOWN};
                    state_next = S_DONE;
                end else if (!sts.slot_busy) begin
                    cmd.op = OP_SLOT_INC;
                end else begin
                    cmd.op     = OP_URD;
                    state_next = S_F_UCHK;
                end
            end
            S_F_UCHK: begin
                if (sts.umatch) begin
                    cmd.op     = OP_UTAKE;
                    state_next = S_F_PTEST;
                end else begin
                    cmd.op     = OP_SLOT_INC;
                    state_next = S_F_UTEST;
                end
            end
            S_F_PTEST: begin
                if (sts.idx_lt_n) begin
                    cmd.op     = OP_FRD;
                    state_next = S_F_PCHK;
                end else begin
                    state_next = S_F_DECIDE;
                end
            end
            S_F_PCHK: begin
                if (sts.below) begin
                    cmd.op     = OP_PREV;
                    state_next = S_F_PTEST;
                end else begin
                    state_next = S_F_DECIDE;
                end
            end
            S_F_DECIDE: begin
                if (!sts.after && !sts.prev_adj && sts.n_full) begin
                    cmd        = '{op: OP_SET_STS, sts: STS_FULL};
                    state_next = S_DONE;
                end else if (sts.after) begin
                    cmd.op     = OP_MERGE_AFTER;
                    state_next = sts.prev_adj ? S_F_MB : S_DONE;
                end else if (sts.prev_adj) begin
                    cmd.op     = OP_MERGE_BEFORE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_INS_START;
                    state_next = S_INS_TEST;
                end
            end
            // merged on both sides: grow the lower one, drop the upper one
            S_F_MB: begin
                cmd.op     = OP_MERGE_BEFORE;
                state_next = S_DROP_TEST;
            end
            S_INS_TEST: begin
                if (sts.ins_more) begin
                    cmd.op     = OP_INS_RD;
                    state_next = S_INS_WR;
                end else begin
                    cmd.op     = OP_INS_PUT;
                    state_next = S_DONE;
                end
            end
            S_INS_WR: begin
                cmd.op     = OP_INS_WR;
                state_next = S_INS_TEST;
            end
            S_Q_TEST: begin
                if (sts.idx_lt_n) begin
                    cmd.op     = OP_FRD;
                    state_next = S_Q_ACC;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_Q_ACC: begin
                cmd.op     = OP_QACC;
                state_next = S_Q_TEST;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign state = state_reg;
endmodule

// ===== rtl/core/ffca_dp.sv =====
module ffca_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wr_data,
    input  logic [25:0]       s_block_count,
    input  logic [31:0]       s_user_address,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [31:0]       m_granted_address,
    output logic [1:0]        m_status,
    output logic [31:0]       m_free_total,
    input  ffca_pkg::dp_cmd_t cmd,
    output ffca_pkg::dp_sts_t sts
);
    import ffca_pkg::*;

    logic [ADDR_BITS-1:0] heap_start_reg, heap_end_reg;
    logic [BB_W-1:0]      block_bytes_reg;

    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [FCNT_W-1:0]    n_reg, n_next, idx_reg, idx_next, jdx_reg, jdx_next;
    logic [UCNT_W-1:0]    slot_reg, slot_next;
    logic [ADDR_BITS-1:0] blk_reg, blk_next, blen_reg, blen_next;
    logic [ADDR_BITS-1:0] prev_hdr_reg, prev_hdr_next, prev_len_reg, prev_len_next;
    logic [ADDR_BITS-1:0] granted_reg, granted_next, total_reg, total_next;
    sts_t                 sts_reg, sts_next;
    logic [USED_SLOTS-1:0] used_valid_reg, used_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ADDR_BITS-1:0] m_granted_reg, m_granted_next, m_total_reg, m_total_next;
    sts_t                 m_status_reg, m_status_next;

    logic                 f_we, f_re, u_we, u_re;
    logic [FIDX_W-1:0]    f_waddr, f_raddr;
    logic [UIDX_W-1:0]    u_waddr, u_raddr;
    logic [ENTRY_W-1:0]   f_wdata, f_rdata, u_wdata, u_rdata;

    logic [ADDR_BITS-1:0] cur_hdr, cur_len, u_hdr, u_len, size_lo, merged;
    logic [ADDR_BITS-1:0] init_hdr, init_len;
    logic [ADDR_BITS:0]   init_need;
    logic [SIZE_W-1:0]    len_ext, diff;
    logic [COUNT_W-1:0]   cnt1;
    logic [FCNT_W-1:0]    idx_p1, idx_m1, jdx_m1;
    logic [UIDX_W-1:0]    slot_i;

    ffca_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_SLOTS)) u_free_ram (
        .clk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
    );

    ffca_ram #(.WIDTH(ENTRY_W), .DEPTH(USED_SLOTS)) u_used_ram (
        .clk(aclk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .re(u_re), .raddr(u_raddr), .rdata(u_rdata)
    );

    assign cur_hdr = f_rdata[ENTRY_W-1:ADDR_BITS];
    assign cur_len = f_rdata[ADDR_BITS-1:0];
    assign u_hdr   = u_rdata[ENTRY_W-1:ADDR_BITS];
    assign u_len   = u_rdata[ADDR_BITS-1:0];
    assign size_lo = size_reg[ADDR_BITS-1:0];
    assign len_ext = {{(SIZE_W-ADDR_BITS){1'b0}}, cur_len};
    assign diff    = len_ext - size_reg;
    assign merged  = blen_reg + HDR_C + cur_len;
    assign cnt1    = (s_block_count == '0) ? COUNT_W'(1) : s_block_count;
    assign idx_p1  = idx_reg + FCNT_W'(1);
    assign idx_m1  = idx_reg - FCNT_W'(1);
    assign jdx_m1  = jdx_reg - FCNT_W'(1);
    assign slot_i  = slot_reg[UIDX_W-1:0];

    // single segment from the heap bounds; too small a heap gives length zero
    assign init_hdr  = heap_start_reg + REGION_OFFSET;
    assign init_need = {1'b0, init_hdr} + (ADDR_BITS+1)'(HEADER_BYTES + 1);
    assign init_len  = ({1'b0, heap_end_reg} >= init_need)
                     ? heap_end_reg - init_need[ADDR_BITS-1:0] : '0;

    always_comb begin
        sts.idx_lt_n  = idx_reg < n_reg;
        sts.drop_more = idx_p1 < n_reg;
        sts.slot_end  = !(slot_reg < UCNT_W'(USED_SLOTS));
        sts.slot_busy = !sts.slot_end && used_valid_reg[slot_i];
        sts.addr_zero = addr_reg == '0;
        sts.fit       = len_ext >= size_reg;
        sts.whole     = diff < SIZE_W'(HEADER_BYTES);
        sts.umatch    = (u_hdr + HDR_C) == addr_reg;
        sts.below     = cur_hdr < blk_reg;
        sts.after     = sts.idx_lt_n && ((blk_reg + blen_reg + HDR_C) == cur_hdr);
        sts.prev_adj  = (idx_reg != '0) && ((prev_hdr_reg + prev_len_reg + HDR_C) == blk_reg);
        sts.n_full    = !(n_reg < FCNT_W'(FREE_SLOTS));
        sts.ins_more  = jdx_reg > idx_reg;
        sts.out_free  = !m_valid_reg || m_ready;
        sts.n_entries = n_reg;
    end

    always_comb begin
        size_next       = size_reg;
        addr_next       = addr_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        jdx_next        = jdx_reg;
        slot_next       = slot_reg;
        blk_next        = blk_reg;
        blen_next       = blen_reg;
        prev_hdr_next   = prev_hdr_reg;
        prev_len_next   = prev_len_reg;
        granted_next    = granted_reg;
        total_next      = total_reg;
        sts_next        = sts_reg;
        used_valid_next = used_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_granted_next  = m_granted_reg;
        m_total_next    = m_total_reg;
        m_status_next   = m_status_reg;
        f_we = 1'b0; f_waddr = idx_reg[FIDX_W-1:0]; f_wdata = f_rdata;
        f_re = 1'b0; f_raddr = idx_reg[FIDX_W-1:0];
        u_we = 1'b0; u_waddr = slot_i; u_wdata = {cur_hdr, cur_len};
        u_re = 1'b0; u_raddr = slot_i;
        case (cmd.op)
            OP_LOAD: begin
                size_next    = {{BB_W{1'b0}}, cnt1} * {{COUNT_W{1'b0}}, block_bytes_reg};
                addr_next    = s_user_address;
                idx_next     = '0;
                slot_next    = '0;
                granted_next = '0;
                total_next   = '0;
                sts_next     = STS_OK;
            end
            OP_INIT: begin
                if (n_reg == '0) begin
                    f_we    = 1'b1;
                    f_waddr = '0;
                    f_wdata = {init_hdr, init_len};
                    n_next  = FCNT_W'(1);
                end
            end
            OP_SLOT_INC: slot_next = slot_reg + UCNT_W'(1);
            OP_FRD:      f_re = 1'b1;
            OP_IDX_INC:  idx_next = idx_p1;
            OP_SET_STS:  sts_next = cmd.sts;
            OP_GRANT_WHOLE: begin
                u_we                    = 1'b1;
                used_valid_next[slot_i] = 1'b1;
                granted_next            = cur_hdr + HDR_C;
            end
            OP_GRANT_SPLIT: begin
                u_we                    = 1'b1;
                u_wdata                 = {cur_hdr, size_lo};
                used_valid_next[slot_i] = 1'b1;
                granted_next            = cur_hdr + HDR_C;
                f_we                    = 1'b1;
                f_wdata = {cur_hdr + size_lo + HDR_C, cur_len - size_lo - HDR_C};
            end
            OP_DROP_RD: begin
                f_re    = 1'b1;
                f_raddr = idx_p1[FIDX_W-1:0];
            end
            OP_DROP_WR: begin
                f_we     = 1'b1;
                idx_next = idx_p1;
            end
            OP_DEC_N: n_next = n_reg - FCNT_W'(1);
            OP_URD:   u_re = 1'b1;
            OP_UTAKE: begin
                blk_next  = u_hdr;
                blen_next = u_len;
                idx_next  = '0;
            end
            OP_PREV: begin
                prev_hdr_next = cur_hdr;
                prev_len_next = cur_len;
                idx_next      = idx_p1;
            end
            OP_MERGE_AFTER: begin
                f_we                    = 1'b1;
                f_wdata                 = {blk_reg, merged};
                blen_next               = merged;
                used_valid_next[slot_i] = 1'b0;
            end
            OP_MERGE_BEFORE: begin
                f_we                    = 1'b1;
                f_waddr                 = idx_m1[FIDX_W-1:0];
                f_wdata = {prev_hdr_reg, prev_len_reg + HDR_C + blen_reg};
                used_valid_next[slot_i] = 1'b0;
            end
            OP_INS_START: begin
                jdx_next                = n_reg;
                used_valid_next[slot_i] = 1'b0;
            end
            OP_INS_RD: begin
                f_re    = 1'b1;
                f_raddr = jdx_m1[FIDX_W-1:0];
            end
            OP_INS_WR: begin
                f_we     = 1'b1;
                f_waddr  = jdx_reg[FIDX_W-1:0];
                jdx_next = jdx_m1;
            end
            OP_INS_PUT: begin
                f_we    = 1'b1;
                f_wdata = {blk_reg, blen_reg};
                n_next  = n_reg + FCNT_W'(1);
            end
            OP_QACC: begin
                total_next = total_reg + cur_len;
                idx_next   = idx_p1;
            end
            OP_EMIT: begin
                m_valid_next   = 1'b1;
                m_granted_next = granted_reg;
                m_total_next   = total_reg;
                m_status_next  = sts_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg  <= HEAP_START_RST;
            heap_end_reg    <= HEAP_END_RST;
            block_bytes_reg <= BLOCK_BYTES_RST;
            n_reg           <= '0;
            used_valid_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HEAP_START:  heap_start_reg  <= cfg_wr_data;
                    CFG_HEAP_END:    heap_end_reg    <= cfg_wr_data;
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_wr_data[BB_W-1:0];
                    default: ;
                endcase
            end
            n_reg          <= n_next;
            used_valid_reg <= used_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        idx_reg       <= idx_next;
        jdx_reg       <= jdx_next;
        slot_reg      <= slot_next;
        blk_reg       <= blk_next;
        blen_reg      <= blen_next;
        prev_hdr_reg  <= prev_hdr_next;
        prev_len_reg  <= prev_len_next;
        granted_reg   <= granted_next;
        total_reg     <= total_next;
        sts_reg       <= sts_next;
        m_granted_reg <= m_granted_next;
        m_total_reg   <= m_total_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_granted_reg;
    assign m_free_total      = m_total_reg;
    assign m_status          = m_status_reg;
endmodule

// ===== rtl/core/first_fit_coalescing_allocator_unit.sv =====
// First-fit heap allocator with coalescing. Free segments (header address,
// length) sit in a 64-entry address-ordered table in RAM, granted blocks in a
// 64-entry used table. One transaction is worked on at a time; each gives one
// result. The table RAMs have separate read and write ports and a registered
// read. Query visits each free segment; allocate searches the used slots,
// then scans segments, then moves entries when a segment is consumed; free
// searches the used slots, then passes segments, then moves entries on insert
// or double merge. A new transaction is taken while the previous result still
// waits on m_ready.
module first_fit_coalescing_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [25:0] s_block_count,
    input  logic [31:0] s_user_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_granted_address,
    output logic [1:0]  m_status,
    output logic [31:0] m_free_total
);
    import ffca_pkg::*;

    `include "assert_macros.svh"

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    state_t  state;

    ffca_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_kind(s_kind),
        .s_ready(s_ready), .sts(dp_sts), .cmd(dp_cmd), .state(state)
    );

    ffca_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_block_count(s_block_count), .s_user_address(s_user_address),
        .m_ready(m_ready), .m_valid(m_valid),
        .m_granted_address(m_granted_address), .m_status(m_status),
        .m_free_total(m_free_total), .cmd(dp_cmd), .sts(dp_sts)
    );

    `FFCA_ASSERT(a_entry_bound, aclk, aresetn, dp_sts.n_entries <= FCNT_W'(FREE_SLOTS), "free table overflow")
    `FFCA_ASSERT(a_accept_busy, aclk, aresetn, (s_valid && s_ready) |=> (state != S_IDLE), "transaction dropped")
    `FFCA_ASSERT(a_emit_done, aclk, aresetn, $rose(m_valid) |-> $past(state == S_DONE), "result outside done")
    `FFCA_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state == S_IDLE), "not idle after reset")
endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import ffca_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_HEAP_START;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_QUERY;
    logic [25:0] s_block_count = '0;
    logic [31:0] s_user_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_granted_address;
    logic [1:0]  m_status;
    logic [31:0] m_free_total;

    typedef struct packed {
        logic [31:0] granted;
        sts_t        status;
        logic [31:0] total;
    } alloc_result_t;

    first_fit_coalescing_allocator_unit i_dut (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic [31:0] heap_lo = HEAP_START_RST;
    logic [31:0] heap_hi = HEAP_END_RST;
    logic [12:0] unit_bytes = BLOCK_BYTES_RST;
    logic [31:0] seg_hdr[FREE_SLOTS];
    logic [31:0] seg_len[FREE_SLOTS];
    int          seg_cnt = 0;
    logic [31:0] blk_hdr[USED_SLOTS];
    logic [31:0] blk_len[USED_SLOTS];
    bit          blk_live[USED_SLOTS];
    logic [31:0] granted_pool[$];

    alloc_result_t pending[$];
    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_ok_alloc = 0;
    int  n_merge = 0;
    int  n_full = 0;
    int  n_unknown = 0;
    int  n_nofit = 0;
    bit  hold_off = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    function automatic void remove_segment(input int pos);
        for (int i = pos; i + 1 < seg_cnt; i++) begin
            seg_hdr[i] = seg_hdr[i+1];
            seg_len[i] = seg_len[i+1];
        end
        seg_cnt--;
    endfunction

    function automatic alloc_result_t predict_alloc(input kind_t kind, input logic [25:0] cnt,
                                                    input logic [31:0] addr);
        alloc_result_t r;
        logic [63:0] want, len;
        logic [31:0] hdr, blk, blen;
        logic [31:0] sum;
        int slot, pos;
        bit aft, bef, done;
        r = '{granted: '0, status: STS_OK, total: '0};
        case (kind)
            KIND_INIT: begin
                if (seg_cnt == 0) begin
                    hdr = heap_lo + REGION_OFFSET;
                    want = 64'(hdr) + 1 + HEADER_BYTES;
                    seg_hdr[0] = hdr;
                    seg_len[0] = (64'(heap_hi) >= want) ? 32'(64'(heap_hi) - want) : '0;
                    seg_cnt = 1;
                end
            end
            KIND_ALLOC: begin
                want = 64'(cnt == 0 ? 26'd1 : cnt) * 64'(unit_bytes);
                slot = 0;
                while (slot < USED_SLOTS && blk_live[slot]) slot++;
                r.status = STS_NO_FIT;
                done = 1'b0;
                for (int i = 0; i < seg_cnt && !done; i++) begin
                    hdr = seg_hdr[i];
                    len = 64'(seg_len[i]);
                    if (len >= want) begin
                        done = 1'b1;
                        if (slot >= USED_SLOTS) begin
                            r.status = STS_FULL;
                            n_full++;
                        end else begin
                            if (len - want < HEADER_BYTES) begin
                                remove_segment(i);
                            end else begin
                                seg_hdr[i] = 32'(64'(hdr) + want + HEADER_BYTES);
                                seg_len[i] = 32'(len - want - HEADER_BYTES);
                                len = want;
                            end
                            blk_hdr[slot] = hdr;
                            blk_len[slot] = 32'(len);
                            blk_live[slot] = 1'b1;
                            r.granted = hdr + HDR_C;
                            r.status = STS_OK;
                            granted_pool.push_back(r.granted);
                            n_ok_alloc++;
                        end
                    end
                end
                if (r.status == STS_NO_FIT) n_nofit++;
            end
            KIND_FREE: begin
                if (addr != 0) begin
                    slot = 0;
                    while (slot < USED_SLOTS && !(blk_live[slot] && blk_hdr[slot] + HDR_C == addr))
                        slot++;
                    if (slot >= USED_SLOTS) begin
                        r.status = STS_UNKNOWN;
                        n_unknown++;
                    end else begin
                        blk = blk_hdr[slot];
                        blen = blk_len[slot];
                        pos = 0;
                        while (pos < seg_cnt && seg_hdr[pos] < blk) pos++;
                        aft = pos < seg_cnt && blk + blen + HDR_C == seg_hdr[pos];
                        bef = pos > 0 && seg_hdr[pos-1] + seg_len[pos-1] + HDR_C == blk;
                        if (!aft && !bef && seg_cnt >= FREE_SLOTS) begin
                            r.status = STS_FULL;
                            n_full++;
                        end else begin
                            if (aft || bef) n_merge++;
                            if (aft) begin
                                blen = blen + HDR_C + seg_len[pos];
                                seg_hdr[pos] = blk;
                                seg_len[pos] = blen;
                                if (bef) begin
                                    seg_len[pos-1] = seg_len[pos-1] + HDR_C + blen;
                                    remove_segment(pos);
                                end
                            end else if (bef) begin
                                seg_len[pos-1] = seg_len[pos-1] + HDR_C + blen;
                            end else begin
                                for (int i = seg_cnt; i > pos; i--) begin
                                    seg_hdr[i] = seg_hdr[i-1];
                                    seg_len[i] = seg_len[i-1];
                                end
                                seg_hdr[pos] = blk;
                                seg_len[pos] = blen;
                                seg_cnt++;
                            end
                            blk_live[slot] = 1'b0;
                            for (int k = 0; k < granted_pool.size(); k++)
                                if (granted_pool[k] == addr) begin
                                    granted_pool.delete(k);
                                    break;
                                end
                        end
                    end
                end
            end
            default: begin
                sum = '0;
                for (int i = 0; i < seg_cnt; i++) sum += seg_len[i];
                r.total = sum;
            end
        endcase
        return r;
    endfunction

    // sender: bursts with random gaps; keeps valid high across a burst
    int burst_left = 0;

    task automatic send_item(input kind_t kind, input logic [25:0] cnt,
                             input logic [31:0] addr);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_kind <= kind;
        s_block_count <= cnt;
        s_user_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending.push_back(predict_alloc(kind, cnt, addr));
        n_sent++;
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_HEAP_START: heap_lo = val;
            CFG_HEAP_END: heap_hi = val;
            default: unit_bytes = val[12:0];
        endcase
    endtask

    // free everything outstanding, then query the free total
    task automatic release_all();
        while (granted_pool.size() != 0) send_item(KIND_FREE, '0, granted_pool[0]);
        send_item(KIND_QUERY, '0, '0);
    endtask

    // receiver stall pattern, plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else case ($urandom_range(0, 7))
            0, 1: m_ready <= 1'b0;
            default: m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        alloc_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                report("unexpected transaction", 32'(m_status), '0);
            end else begin
                w = pending.pop_front();
                if (m_granted_address !== w.granted)
                    report("granted_address", m_granted_address, w.granted);
                if (m_status !== w.status) report("status", 32'(m_status), 32'(w.status));
                if (m_free_total !== w.total) report("free_total", m_free_total, w.total);
                n_checked++;
            end
        end
    end

    task automatic test_directed();
        send_item(KIND_QUERY, '0, '0);
        send_item(KIND_FREE, '0, '0);
        send_item(KIND_FREE, '0, 32'h0100_0010);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_INIT, '0, '0);
        send_item(KIND_INIT, '0, '0);
        send_item(KIND_QUERY, '0, '0);
        send_item(KIND_ALLOC, '0, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC, 26'h3FF_FFFF, '0);
        send_item(KIND_ALLOC, 26'd3, '0);
        send_item(KIND_ALLOC, 26'd1, '0);
        send_item(KIND_FREE, '0, 32'h0100_0010);
        send_item(KIND_FREE, '0, 32'h0100_0010);
        send_item(KIND_FREE, '0, granted_pool[granted_pool.size()-1]);
        send_item(KIND_QUERY, '0, '0);
        release_all();
        idle_sender();
        drain();
    endtask

    // reconfigure with a fresh (empty) free table requires no segments; we
    // cannot empty the table, so new heaps only matter for init when empty.
    // Config changes still affect block size of later allocs.
    task automatic test_block_sizes();
        logic [12:0] sizes[4] = '{13'd1, 13'd4096, 13'd0, 13'd64};
        foreach (sizes[i]) begin
            write_reg(CFG_BLOCK_BYTES, 32'(sizes[i]));
            for (int j = 0; j < 20; j++)
                send_item(KIND_ALLOC, 26'($urandom_range(0, 40)), '0);
            send_item(KIND_ALLOC, 26'h3FF_FFFF, '0);
            send_item(KIND_QUERY, '0, '0);
            release_all();
            idle_sender();
            drain();
        end
    endtask

    // exhaust used slots, then free in scattered order to fill free table
    task automatic test_tables_full();
        logic [31:0] a;
        write_reg(CFG_BLOCK_BYTES, 32'd16);
        for (int j = 0; j < 70; j++) send_item(KIND_ALLOC, 26'd1, '0);
        for (int j = 0; j < granted_pool.size(); j += 2) begin
            a = granted_pool[j];
            send_item(KIND_FREE, '0, a);
            j--;
        end
        release_all();
        idle_sender();
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int j = 0; j < 30; j++) send_item(KIND_QUERY, '0, '0);
        join
        idle_sender();
        drain();
    endtask

    task automatic test_random(input int items);
        int pick;
        logic [31:0] a;
        write_reg(CFG_BLOCK_BYTES, 32'($urandom_range(1, 256)));
        for (int j = 0; j < items; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_item(KIND_ALLOC, ($urandom_range(0, 9) == 0) ? 26'($urandom)
                                                                 : 26'($urandom_range(0, 64)), '0);
            end else if (pick < 85 && granted_pool.size() != 0) begin
                send_item(KIND_FREE, '0,
                          granted_pool[$urandom_range(0, granted_pool.size() - 1)]);
            end else if (pick < 92) begin
                a = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 3);
                send_item(KIND_FREE, '0, a);
            end else if (pick < 97) begin
                send_item(KIND_QUERY, '0, '0);
            end else begin
                send_item(KIND_INIT, 26'($urandom), $urandom);
            end
        end
        release_all();
        idle_sender();
        drain();
    endtask

    // fresh heap setups via reset-free path: only the first init creates the
    // table, so heap registers are exercised before the first init.
    task automatic test_heap_regs();
        write_reg(CFG_HEAP_START, 32'hFFFF_FFF0);
        write_reg(CFG_HEAP_END, 32'hFFFF_FFFF);
        write_reg(CFG_BLOCK_BYTES, 32'd4096);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_heap_regs();
        write_reg(CFG_HEAP_START, '0);
        write_reg(CFG_HEAP_END, HEAP_END_RST);
        write_reg(CFG_BLOCK_BYTES, 32'(BLOCK_BYTES_RST));
        test_directed();
        test_block_sizes();
        test_tables_full();
        test_backpressure();
        test_random(1100);
        // registers moved to extremes after setup (no effect on a live table)
        write_reg(CFG_HEAP_START, 32'hFFFF_FFFF);
        write_reg(CFG_HEAP_END, '0);
        send_item(KIND_INIT, '0, '0);
        send_item(KIND_QUERY, '0, '0);
        idle_sender();
        drain();
        $display("Checked %0d of %0d transactions: %0d grants, %0d merges, %0d no-fit,",
                 n_checked, n_sent, n_ok_alloc, n_merge, n_nofit);
        $display("%0d table-full and %0d unknown-address responses", n_full, n_unknown);
        if (errors == 0 && pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
